>>> hw/rtl/yfr_pkg.sv
// shared types, constants and crc helper for the ymodem block framer
`timescale 1ns / 1ps

package yfr_pkg;

  localparam int unsigned SHORT_BLOCK_BYTES = 128;
  localparam int unsigned QUEUE_DEPTH       = 2;

  localparam logic [7:0]  START_SHORT = 8'h01;
  localparam logic [7:0]  START_LONG  = 8'h02;
  localparam logic [7:0]  EOT_BYTE    = 8'h04;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  typedef enum logic [1:0] {
    CMD_EOT,
    CMD_DATA,
    CMD_HEAD,
    CMD_TAIL
  } cmd_kind_e;

  // one classified input item, as handed from front to back
  typedef struct packed {
    cmd_kind_e   kind;
    logic        long_blk;
    logic [7:0]  seq;
    logic [7:0]  data;
    logic [15:0] crc;
  } cmd_t;

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // index of the final output byte of a command
  function automatic logic [1:0] last_step(input cmd_kind_e kind);
    logic [1:0] s;
    case (kind)
      CMD_HEAD: s = 2'd3;
      CMD_TAIL: s = 2'd2;
      default:  s = 2'd0;
    endcase
    return s;
  endfunction

endpackage

>>> hw/rtl/ymodem_block_framer.sv
// top level of the ymodem block framer
`timescale 1ns / 1ps

// Frames payload positions into YMODEM blocks (start byte, sequence, its
// complement, payload, CRC-16/XMODEM high then low byte) and sends a lone EOT
// on request. The back end puts out one line byte per cycle while out_ready_i
// is high, so a middle position yields one line byte, the first of a block four
// (three header bytes plus the payload byte), the last three (payload plus two
// crc bytes), an EOT one. The single byte-wide output port of the back end sets
// the pace; a two-entry command queue lets input keep flowing while header or
// crc bytes drain. No clearing pass after reset.
module ymodem_block_framer import yfr_pkg::*; #(
  parameter int unsigned LONG_BLOCK_BYTES = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       req_type_i,
  input  logic       block_long_i,
  input  logic [7:0] data_byte_i,
  input  logic       is_pad_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       frame_end_o
);

  cmd_t front_cmd, queue_cmd;
  logic full, empty, pop, accept;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  yfr_front #(
    .LONG_BLOCK_BYTES(LONG_BLOCK_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_type_i  (req_type_i),
    .block_long_i(block_long_i),
    .data_byte_i (data_byte_i),
    .is_pad_i    (is_pad_i),
    .cmd_o       (front_cmd)
  );

  yfr_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .cmd_i  (front_cmd),
    .full_o (full),
    .pop_i  (pop),
    .cmd_o  (queue_cmd),
    .empty_o(empty)
  );

  yfr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (queue_cmd),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .run_last_o (run_last_o),
    .frame_end_o(frame_end_o)
  );

endmodule

>>> hw/rtl/yfr_front.sv
// front end: block position, sequence and crc tracking, command classification
`timescale 1ns / 1ps

module yfr_front import yfr_pkg::*; #(
  parameter int unsigned LONG_BLOCK_BYTES = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       req_type_i,
  input  logic       block_long_i,
  input  logic [7:0] data_byte_i,
  input  logic       is_pad_i,
  output cmd_t       cmd_o
);

  localparam int unsigned POS_W = $clog2(LONG_BLOCK_BYTES + 1);

  logic [POS_W-1:0] pos_q, pos_d, pos_inc, size;
  logic [7:0]       seq_q, seq_d;
  logic [15:0]      crc_q, crc_d, crc_new;
  logic             long_q, long_d;
  logic             first, last, lb;
  logic [7:0]       b;

  always_comb begin
    first   = (pos_q == '0);
    lb      = first ? block_long_i : long_q;
    b       = is_pad_i ? 8'h00 : data_byte_i;
    crc_new = crc16_update(first ? 16'h0000 : crc_q, b);
    size    = lb ? POS_W'(LONG_BLOCK_BYTES) : POS_W'(SHORT_BLOCK_BYTES);
    pos_inc = pos_q + POS_W'(1);
    last    = (pos_inc >= size);

    seq_d  = seq_q;
    long_d = long_q;
    pos_d  = pos_q;
    crc_d  = crc_q;

    cmd_o.kind     = CMD_DATA;
    cmd_o.long_blk = lb;
    cmd_o.seq      = seq_q;
    cmd_o.data     = b;
    cmd_o.crc      = crc_new;

    if (req_type_i) begin
      cmd_o.kind = CMD_EOT;
      pos_d      = '0;
      crc_d      = '0;
    end else begin
      if (first) begin
        long_d    = block_long_i;
        seq_d     = block_long_i ? seq_q + 8'd1 : 8'd0;
        cmd_o.seq = seq_d;
      end
      cmd_o.kind = first ? CMD_HEAD : (last ? CMD_TAIL : CMD_DATA);
      pos_d      = last ? '0 : pos_inc;
      crc_d      = last ? 16'h0000 : crc_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      seq_q  <= '0;
      crc_q  <= '0;
      long_q <= 1'b0;
    end else if (accept_i) begin
      pos_q  <= pos_d;
      seq_q  <= seq_d;
      crc_q  <= crc_d;
      long_q <= long_d;
    end
  end

endmodule

>>> hw/rtl/yfr_fifo.sv
// short command queue between front and back
`timescale 1ns / 1ps

module yfr_fifo import yfr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_q];

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wrap_inc(wr_q);
      if (do_pop)  rd_q <= wrap_inc(rd_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cmd_i;
  end

endmodule

>>> hw/rtl/yfr_back.sv
// back end: expands each command into its framed line bytes
`timescale 1ns / 1ps

module yfr_back import yfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       frame_end_o
);

  cmd_t       cmd_q;
  logic       busy_q;
  logic [1:0] step_q;
  logic       xfer, done, load;

  assign xfer  = busy_q && out_ready_i;
  assign done  = xfer && (step_q == last_step(cmd_q.kind));
  assign load  = (!busy_q || done) && !empty_i;
  assign pop_o = load;
  assign out_valid_o = busy_q;

  always_comb begin
    out_byte_o  = cmd_q.data;
    run_last_o  = (step_q == last_step(cmd_q.kind));
    frame_end_o = 1'b0;
    case (cmd_q.kind)
      CMD_EOT: begin
        out_byte_o  = EOT_BYTE;
        frame_end_o = 1'b1;
      end
      CMD_HEAD: begin
        case (step_q)
          2'd0:    out_byte_o = cmd_q.long_blk ? START_LONG : START_SHORT;
          2'd1:    out_byte_o = cmd_q.seq;
          2'd2:    out_byte_o = ~cmd_q.seq;
          default: out_byte_o = cmd_q.data;
        endcase
      end
      CMD_TAIL: begin
        case (step_q)
          2'd0:    out_byte_o = cmd_q.data;
          2'd1:    out_byte_o = cmd_q.crc[15:8];
          default: begin
            out_byte_o  = cmd_q.crc[7:0];
            frame_end_o = 1'b1;
          end
        endcase
      end
      default: out_byte_o = cmd_q.data;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (done) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (xfer) begin
      step_q <= step_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) cmd_q <= cmd_i;
  end

  a_fend_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> run_last_o)
    else $error("frame end on a byte that is not the last of its item");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= last_step(cmd_q.kind))
    else $error("byte step beyond the command length");

  a_load_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> busy_q && step_q == 2'd0)
    else $error("loaded command does not start at its first byte");

  a_no_pop_midway: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !done |-> !pop_o)
    else $error("command popped while the current one is unfinished");

endmodule

>>> bench/yfr_tb_pkg.sv
// request codes shared by the framer testbench files
`timescale 1ns / 1ps

package yfr_tb_pkg;

  typedef enum logic {
    REQ_POSITION = 1'b0,
    REQ_EOT      = 1'b1
  } req_kind_e;

endpackage

>>> bench/yfr_line_checker.sv
// line-side checker for the ymodem block framer: predicts framed bytes and compares them
`timescale 1ns / 1ps

module yfr_line_checker import yfr_pkg::*; import yfr_tb_pkg::*; #(
  parameter int unsigned LONG_BYTES = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic       req_type_i,
  input  logic       block_long_i,
  input  logic [7:0] data_byte_i,
  input  logic       is_pad_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_byte_i,
  input  logic       run_last_i,
  input  logic       frame_end_i,
  output int         errors_o,
  output int         pending_o,
  output int         checked_o,
  output int         blocks_o
);

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       fend;
  } line_byte_t;

  line_byte_t  line_q[$];

  logic [10:0] blk_pos;
  logic [7:0]  blk_seq;
  logic [15:0] blk_crc;
  logic        blk_long;

  // bit-serial form of crc-16/xmodem, one payload byte msb first
  function automatic logic [15:0] crc_xmodem_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      if (r[15] ^ b[k]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  // line bytes caused by one accepted request, appended to line_q
  task automatic frame_position(input logic req, input logic blong, input logic [7:0] data,
                                input logic pad);
    line_byte_t  bytes [4];
    int          n;
    logic [7:0]  b;
    int unsigned size;
    n = 0;
    if (req == REQ_EOT) begin
      // a partial block is dropped, sequence kept
      bytes[0] = '{EOT_BYTE, 1'b0, 1'b1};
      n = 1;
      blk_pos = '0;
      blk_crc = '0;
    end else begin
      if (blk_pos == '0) begin
        blk_long = blong;
        blk_seq  = blong ? blk_seq + 8'd1 : 8'd0;
        bytes[0] = '{blong ? START_LONG : START_SHORT, 1'b0, 1'b0};
        bytes[1] = '{blk_seq, 1'b0, 1'b0};
        bytes[2] = '{8'hFF - blk_seq, 1'b0, 1'b0};
        n = 3;
        blk_crc = '0;
      end
      b = pad ? 8'h00 : data;
      bytes[n] = '{b, 1'b0, 1'b0};
      n++;
      blk_crc = crc_xmodem_step(blk_crc, b);
      size = blk_long ? LONG_BYTES : SHORT_BLOCK_BYTES;
      blk_pos = blk_pos + 11'd1;
      if (blk_pos >= size) begin
        bytes[n]     = '{blk_crc[15:8], 1'b0, 1'b0};
        bytes[n + 1] = '{blk_crc[7:0], 1'b0, 1'b1};
        n += 2;
        blk_pos = '0;
        blk_crc = '0;
        blocks_o++;
      end
    end
    bytes[n - 1].last = 1'b1;
    for (int k = 0; k < n; k++) line_q.push_back(bytes[k]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    line_byte_t want;
    if (!rst_ni) begin
      line_q.delete();
      blk_pos   = '0;
      blk_seq   = '0;
      blk_crc   = '0;
      blk_long  = 1'b0;
      pending_o = 0;
    end else begin
      // predict first so a same-cycle result would still find its expectation
      if (in_valid_i && in_ready_i) begin
        frame_position(req_type_i, block_long_i, data_byte_i, is_pad_i);
      end
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (line_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected line byte: expected none, got %02h run_last %0b frame_end %0b",
                   $time, out_byte_i, run_last_i, frame_end_i);
        end else begin
          want = line_q.pop_front();
          if (out_byte_i !== want.value || run_last_i !== want.last ||
              frame_end_i !== want.fend) begin
            errors_o++;
            if (out_byte_i !== want.value)
              $display("%0t: out_byte expected %02h got %02h", $time, want.value, out_byte_i);
            if (run_last_i !== want.last)
              $display("%0t: run_last expected %0b got %0b", $time, want.last, run_last_i);
            if (frame_end_i !== want.fend)
              $display("%0t: frame_end expected %0b got %0b", $time, want.fend, frame_end_i);
          end
        end
      end
      pending_o = line_q.size();
    end
  end

endmodule

>>> bench/tb_top.sv
// top of the ymodem block framer testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
  import yfr_pkg::*;
  import yfr_tb_pkg::*;

  localparam int unsigned LONG_BLOCK_BYTES = 1024;
  localparam int unsigned IDLE_PCT         = 27;
  localparam int unsigned RANDOM_ITEMS     = 300;
  localparam int unsigned STALL_LIMIT      = 2000;
  localparam int unsigned DRAIN_CYCLES     = 16;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       req_type_i;
  logic       block_long_i;
  logic [7:0] data_byte_i;
  logic       is_pad_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic       run_last_o;
  logic       frame_end_o;

  int errors;
  int pending;
  int checked;
  int blocks;
  int items_sent;
  int eot_sent;
  int quiet_cycles;
  bit steady;

  always #5 clk_i = ~clk_i;

  ymodem_block_framer #(
    .LONG_BLOCK_BYTES(LONG_BLOCK_BYTES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .block_long_i(block_long_i),
    .data_byte_i (data_byte_i),
    .is_pad_i    (is_pad_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .frame_end_o (frame_end_o)
  );

  yfr_line_checker #(
    .LONG_BYTES(LONG_BLOCK_BYTES)
  ) line_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .req_type_i  (req_type_i),
    .block_long_i(block_long_i),
    .data_byte_i (data_byte_i),
    .is_pad_i    (is_pad_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_i  (out_byte_o),
    .run_last_i  (run_last_o),
    .frame_end_i (frame_end_o),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked),
    .blocks_o    (blocks)
  );

  // line side backpressure
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d line bytes still due",
               $time, quiet_cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // valid held with a stable payload until the transfer
  task automatic send_item(input req_kind_e kind, input logic blong, input logic [7:0] data,
                           input logic pad);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= kind;
    block_long_i <= blong;
    data_byte_i  <= data;
    is_pad_i     <= pad;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    if (kind == REQ_EOT) eot_sent++;
  endtask

  task automatic send_eot();
    send_item(REQ_EOT, 1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // consecutive payload positions; block_long only matters on the first
  task automatic send_run(input logic is_long, input int count, input int pad_from);
    for (int i = 0; i < count; i++) begin
      send_item(REQ_POSITION, (i == 0) ? is_long : 1'($urandom_range(1)),
                8'($urandom_range(255)), i >= pad_from);
    end
  endtask

  initial begin : stimulus
    int        base;
    int        pick;
    req_kind_e kind;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    req_type_i   = REQ_POSITION;
    block_long_i = 1'b0;
    data_byte_i  = 8'h00;
    is_pad_i     = 1'b0;
    steady       = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // eot straight out of reset, then a short header with extreme data
    send_item(REQ_EOT, 1'b0, 8'h00, 1'b0);
    send_item(REQ_POSITION, 1'b0, 8'hFF, 1'b0);
    send_item(REQ_POSITION, 1'b1, 8'h00, 1'b0);
    send_item(REQ_POSITION, 1'b0, 8'hA5, 1'b1);
    // eot inside a block drops it
    send_item(REQ_EOT, 1'b1, 8'hFF, 1'b1);
    send_item(REQ_POSITION, 1'b1, 8'h80, 1'b0);
    send_item(REQ_POSITION, 1'b0, 8'hFF, 1'b1);
    send_item(REQ_POSITION, 1'b0, 8'h7F, 1'b0);
    send_item(REQ_EOT, 1'b0, 8'h5A, 1'b0);
    send_item(REQ_POSITION, 1'b1, 8'h01, 1'b0);
    send_item(REQ_EOT, 1'b1, 8'h00, 1'b0);
    // short block puts the sequence back to zero
    send_item(REQ_POSITION, 1'b0, 8'h01, 1'b0);
    send_item(REQ_EOT, 1'b0, 8'hFF, 1'b0);
    send_item(REQ_POSITION, 1'b1, 8'hFE, 1'b1);
    send_item(REQ_POSITION, 1'b1, 8'h00, 1'b1);
    send_item(REQ_EOT, 1'b0, 8'h00, 1'b1);

    // a complete short block with both sides never idling
    steady <= 1'b1;
    send_run(1'b0, SHORT_BLOCK_BYTES, 100);
    steady <= 1'b0;

    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        send_run(1'b0, SHORT_BLOCK_BYTES, $urandom_range(64, SHORT_BLOCK_BYTES));
        if ($urandom_range(1)) send_eot();
      end else if (pick < 50) begin
        send_run(1'b1, $urandom_range(1, 40), $urandom_range(1, 48));
        send_eot();
      end else if (pick < 75) begin
        send_run(1'b0, $urandom_range(1, 40), $urandom_range(1, 48));
        send_eot();
      end else begin
        repeat ($urandom_range(1, 8)) begin
          kind = ($urandom_range(3) == 0) ? REQ_EOT : REQ_POSITION;
          send_item(kind, 1'($urandom_range(1)), 8'($urandom_range(255)),
                    1'($urandom_range(1)));
        end
        send_eot();
      end
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d requests (%0d eot), %0d blocks closed with crc,",
             items_sent, eot_sent, blocks);
    $display("long block starts, eot inside open blocks and %0d line bytes compared", checked);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
